// File: src/c2e_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the cube-face to equirectangular address block.
// No dependencies.
package c2e_pkg;

   localparam int MAX_EDGE_LEN   = 4096;
   localparam int MAX_SRC_WIDTH  = 8192;
   localparam int MAX_SRC_HEIGHT = 4096;

   localparam int FACE_W      = 3;
   localparam int COORD_W     = 12;
   localparam int FS_W        = 13;
   localparam int SW_W        = 14;
   localparam int SH_W        = 13;
   localparam int SRC_COL_W   = 13;
   localparam int SRC_ROW_W   = 12;
   localparam int SRC_IDX_W   = 25;
   localparam int Q_W         = 18;
   localparam int SQ_W        = 36;
   localparam int ROOT_W      = 18;
   localparam int CORDIC_IN_W = 19;
   localparam int CORDIC_W    = 22;
   localparam int ANG_W       = 22;
   localparam int FRAC_W      = 17;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   localparam int DIV_STEPS    = 18;
   localparam int SQRT_STEPS   = 18;
   localparam int CORDIC_STEPS = 16;

   localparam logic [Q_W-1:0]        Q_ONE_U    = 18'd65536;
   localparam logic [Q_W-1:0]        Q_SAT_U    = 18'd196607;
   localparam logic signed [Q_W-1:0] Q_ONE      = 18'sd65536;
   localparam logic signed [ANG_W-1:0] HALF_TURN = 22'sd524288;
   localparam logic [FRAC_W-1:0]     FRAC_ONE   = 17'd65536;

   localparam logic signed [ANG_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
      22'sd131072, 22'sd77376, 22'sd40884, 22'sd20753,
      22'sd10417,  22'sd5213,  22'sd2607,  22'sd1304,
      22'sd652,    22'sd326,   22'sd163,   22'sd81,
      22'sd41,     22'sd20,    22'sd10,    22'sd5
   };

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_POS_Z = 3'd4,
      FACE_NEG_Z = 3'd5
   } face_type;

   typedef enum logic [1:0] {
      REG_EDGE_LEN   = 2'd0,
      REG_SRC_WIDTH  = 2'd1,
      REG_SRC_HEIGHT = 2'd2
   } reg_index_type;

endpackage

// File: src/c2e_req_if.sv
`timescale 1ns / 1ps
// Input channel: one cube-face pixel per transfer.
// Depends on c2e_pkg.
interface c2e_req_if;
   logic                          valid;
   logic                          ready;
   logic [c2e_pkg::FACE_W-1:0]    face;
   logic [c2e_pkg::COORD_W-1:0]   col;
   logic [c2e_pkg::COORD_W-1:0]   row;

   modport source (output valid, face, col, row, input ready);
   modport sink (input valid, face, col, row, output ready);
endinterface

// File: src/c2e_rsp_if.sv
`timescale 1ns / 1ps
// Result channel: one equirectangular source address per transfer.
// Depends on c2e_pkg.
interface c2e_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [c2e_pkg::SRC_COL_W-1:0]   src_col;
   logic [c2e_pkg::SRC_ROW_W-1:0]   src_row;
   logic [c2e_pkg::SRC_IDX_W-1:0]   src_index;

   modport source (output valid, src_col, src_row, src_index, input ready);
   modport sink (input valid, src_col, src_row, src_index, output ready);
endinterface

// File: src/c2e_delay.sv
`timescale 1ns / 1ps
// Enabled shift line that aligns side data with the arithmetic units.
// No dependencies.
module c2e_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

// File: src/c2e_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: face coordinate ((2c+1)<<16)/edge length - 1.0 in Q2.16.
// One quotient bit per stage, saturated output. Depends on c2e_pkg.
module c2e_div (
   input  logic                               clock,
   input  logic                               en,
   input  logic [c2e_pkg::COORD_W-1:0]        coord,
   input  logic [c2e_pkg::FS_W-1:0]           divisor,
   output logic signed [c2e_pkg::Q_W-1:0]     q_out
);

   localparam int STEPS = c2e_pkg::DIV_STEPS;
   localparam int RW    = c2e_pkg::FS_W;

   logic [RW-1:0]    rem_ff  [STEPS];
   logic [STEPS-1:0] quo_ff  [STEPS];
   logic             ovf_ff  [STEPS];
   logic [RW-1:0]    rem_in  [STEPS];
   logic [STEPS-1:0] quo_in  [STEPS];
   logic             ovf_in  [STEPS];
   logic [RW-1:0]    rem_prv [STEPS];
   logic [STEPS-1:0] quo_prv [STEPS];
   logic             bit_prv [STEPS];

   logic [RW-1:0] num_hi;
   logic [c2e_pkg::Q_W-1:0] q_sat;

   assign num_hi = RW'(coord[c2e_pkg::COORD_W-1:1]);

   genvar k;
   generate
      for (k = 0; k < STEPS; k++) begin : g_step
         if (k == 0) begin : g_first
            assign rem_prv[k] = num_hi;
            assign quo_prv[k] = '0;
            assign bit_prv[k] = coord[0];
            assign ovf_in[k]  = (num_hi >= divisor);
         end else begin : g_rest
            assign rem_prv[k] = rem_ff[k-1];
            assign quo_prv[k] = quo_ff[k-1];
            assign bit_prv[k] = (k == 1);
            assign ovf_in[k]  = ovf_ff[k-1];
         end

         always_comb begin
            logic [RW:0] trial;
            logic        ge;
            trial = {rem_prv[k], bit_prv[k]};
            ge = (trial >= {1'b0, divisor});
            rem_in[k] = ge ? RW'(trial - {1'b0, divisor}) : RW'(trial);
            quo_in[k] = {quo_prv[k][STEPS-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= rem_in[k];
               quo_ff[k] <= quo_in[k];
               ovf_ff[k] <= ovf_in[k];
            end
         end
      end
   endgenerate

   always_comb begin
      if (ovf_ff[STEPS-1] || quo_ff[STEPS-1] > c2e_pkg::Q_SAT_U) begin
         q_sat = c2e_pkg::Q_SAT_U;
      end else begin
         q_sat = quo_ff[STEPS-1];
      end
      q_out = signed'(q_sat - c2e_pkg::Q_ONE_U);
   end

endmodule

// File: src/c2e_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
// Depends on c2e_pkg.
module c2e_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [c2e_pkg::SQ_W-1:0]      radicand,
   output logic [c2e_pkg::ROOT_W-1:0]    root
);

   localparam int STEPS = c2e_pkg::SQRT_STEPS;
   localparam int W     = c2e_pkg::SQ_W;

   logic [W-1:0] n_ff   [STEPS];
   logic [W-1:0] res_ff [STEPS];
   logic [W-1:0] n_in   [STEPS];
   logic [W-1:0] res_in [STEPS];
   logic [W-1:0] n_prv  [STEPS];
   logic [W-1:0] res_prv[STEPS];

   genvar k;
   generate
      for (k = 0; k < STEPS; k++) begin : g_step
         localparam logic [W-1:0] ONE_BIT = W'(1) << (2 * (STEPS - 1 - k));

         if (k == 0) begin : g_first
            assign n_prv[k]   = radicand;
            assign res_prv[k] = '0;
         end else begin : g_rest
            assign n_prv[k]   = n_ff[k-1];
            assign res_prv[k] = res_ff[k-1];
         end

         always_comb begin
            logic [W:0] trial;
            trial = {1'b0, res_prv[k]} + {1'b0, ONE_BIT};
            if ({1'b0, n_prv[k]} >= trial) begin
               n_in[k]   = W'({1'b0, n_prv[k]} - trial);
               res_in[k] = (res_prv[k] >> 1) + ONE_BIT;
            end else begin
               n_in[k]   = n_prv[k];
               res_in[k] = res_prv[k] >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               n_ff[k]   <= n_in[k];
               res_ff[k] <= res_in[k];
            end
         end
      end
   endgenerate

   assign root = res_ff[STEPS-1][c2e_pkg::ROOT_W-1:0];

endmodule

// File: src/c2e_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: atan2(num, den) in units of 2^-20 turn.
// Quadrant fold stage, then one micro-rotation per stage. Depends on c2e_pkg.
module c2e_cordic (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [c2e_pkg::CORDIC_IN_W-1:0]  num,
   input  logic signed [c2e_pkg::CORDIC_IN_W-1:0]  den,
   output logic signed [c2e_pkg::ANG_W-1:0]        angle
);

   localparam int STEPS = c2e_pkg::CORDIC_STEPS;
   localparam int W     = c2e_pkg::CORDIC_W;
   localparam int AW    = c2e_pkg::ANG_W;

   logic signed [W-1:0]  num_ff  [STEPS+1];
   logic signed [W-1:0]  den_ff  [STEPS+1];
   logic signed [AW-1:0] ang_ff  [STEPS+1];
   logic                 zero_ff [STEPS+1];

   logic signed [W-1:0]  num_ext, den_ext, num0_in, den0_in;
   logic signed [AW-1:0] ang0_in;

   assign num_ext = W'(num);
   assign den_ext = W'(den);

   always_comb begin
      if (den_ext < 0) begin
         ang0_in = (num_ext >= 0) ? c2e_pkg::HALF_TURN : -c2e_pkg::HALF_TURN;
         num0_in = -num_ext;
         den0_in = -den_ext;
      end else begin
         ang0_in = '0;
         num0_in = num_ext;
         den0_in = den_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0]  <= num0_in;
         den_ff[0]  <= den0_in;
         ang_ff[0]  <= ang0_in;
         zero_ff[0] <= (num_ext == 0) && (den_ext == 0);
      end
   end

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_iter
         logic signed [W-1:0]  num_in, den_in;
         logic signed [AW-1:0] ang_in;

         always_comb begin
            if (num_ff[i] >= 0) begin
               den_in = den_ff[i] + (num_ff[i] >>> i);
               num_in = num_ff[i] - (den_ff[i] >>> i);
               ang_in = ang_ff[i] + c2e_pkg::ATAN_TURNS[i];
            end else begin
               den_in = den_ff[i] - (num_ff[i] >>> i);
               num_in = num_ff[i] + (den_ff[i] >>> i);
               ang_in = ang_ff[i] - c2e_pkg::ATAN_TURNS[i];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[i+1]  <= num_in;
               den_ff[i+1]  <= den_in;
               ang_ff[i+1]  <= ang_in;
               zero_ff[i+1] <= zero_ff[i];
            end
         end
      end
   endgenerate

   assign angle = zero_ff[STEPS] ? '0 : ang_ff[STEPS];

endmodule

// File: src/cubemap_to_equirect_address.sv
`timescale 1ns / 1ps
// Cube-face pixel to equirectangular source address, top level.
// Depends on c2e_pkg, c2e_req_if, c2e_rsp_if, c2e_delay, c2e_div, c2e_sqrt, c2e_cordic.
//
// Takes one face pixel per clock unless the output stalls and returns its source
// column, row and linear index. The 60-stage pipeline is set by the two parallel
// 18-step coordinate dividers, then the 18-step square root and 17-stage polar
// CORDIC unit; the longitude CORDIC runs beside the root. The whole pipeline
// holds while a result waits on the output. Registers: face edge length at 0x0,
// src_width at 0x4, src_height at 0x8; write them only while the block is idle.
module cubemap_to_equirect_address (
   input  logic                               clock,
   input  logic                               reset,
   c2e_req_if.sink                            req_chan,
   c2e_rsp_if.source                          rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [c2e_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [c2e_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [c2e_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int DEPTH = 60;
   localparam int QW    = c2e_pkg::Q_W;
   localparam int CIW   = c2e_pkg::CORDIC_IN_W;
   localparam int AW    = c2e_pkg::ANG_W;
   localparam int FW    = c2e_pkg::FRAC_W;

   // configuration
   logic [c2e_pkg::FS_W-1:0] edge_len_ff;
   logic [c2e_pkg::SW_W-1:0] src_width_ff;
   logic [c2e_pkg::SH_W-1:0] src_height_ff;
   logic [c2e_pkg::FS_W-1:0] fs_use;
   logic [c2e_pkg::SW_W-1:0] sw_use;
   logic [c2e_pkg::SH_W-1:0] sh_use;
   logic [c2e_pkg::SRC_COL_W-1:0] sw_m1;
   logic [c2e_pkg::SRC_ROW_W-1:0] sh_m1;
   c2e_pkg::reg_index_type csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx = c2e_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_len_ff   <= 13'd1024;
         src_width_ff  <= 14'd2048;
         src_height_ff <= 13'd1024;
      end else if (csr_wr) begin
         unique case (csr_idx)
            c2e_pkg::REG_EDGE_LEN:   edge_len_ff   <= csr_pwdata[c2e_pkg::FS_W-1:0];
            c2e_pkg::REG_SRC_WIDTH:  src_width_ff  <= csr_pwdata[c2e_pkg::SW_W-1:0];
            c2e_pkg::REG_SRC_HEIGHT: src_height_ff <= csr_pwdata[c2e_pkg::SH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         c2e_pkg::REG_EDGE_LEN:   csr_prdata = 32'(edge_len_ff);
         c2e_pkg::REG_SRC_WIDTH:  csr_prdata = 32'(src_width_ff);
         c2e_pkg::REG_SRC_HEIGHT: csr_prdata = 32'(src_height_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (edge_len_ff == '0) begin
         fs_use = 13'd1;
      end else if (edge_len_ff > 13'(c2e_pkg::MAX_EDGE_LEN)) begin
         fs_use = 13'(c2e_pkg::MAX_EDGE_LEN);
      end else begin
         fs_use = edge_len_ff;
      end
      if (src_width_ff < 14'd2) begin
         sw_use = 14'd2;
      end else if (src_width_ff > 14'(c2e_pkg::MAX_SRC_WIDTH)) begin
         sw_use = 14'(c2e_pkg::MAX_SRC_WIDTH);
      end else begin
         sw_use = src_width_ff;
      end
      if (src_height_ff < 13'd2) begin
         sh_use = 13'd2;
      end else if (src_height_ff > 13'(c2e_pkg::MAX_SRC_HEIGHT)) begin
         sh_use = 13'(c2e_pkg::MAX_SRC_HEIGHT);
      end else begin
         sh_use = src_height_ff;
      end
      sw_m1 = c2e_pkg::SRC_COL_W'(sw_use - 14'd1);
      sh_m1 = c2e_pkg::SRC_ROW_W'(sh_use - 13'd1);
   end

   // pipeline control
   logic [DEPTH-1:0] vld_ff;
   logic             en;

   assign en = !vld_ff[DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_chan.valid};
      end
   end

   // input register
   logic [c2e_pkg::FACE_W-1:0]  face0_ff;
   logic [c2e_pkg::COORD_W-1:0] col0_ff;
   logic [c2e_pkg::COORD_W-1:0] row0_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         face0_ff <= req_chan.face;
         col0_ff  <= req_chan.col;
         row0_ff  <= req_chan.row;
      end
   end

   // face coordinates
   logic signed [QW-1:0] u_q, v_q;
   logic [c2e_pkg::FACE_W-1:0] face18;

   c2e_div u_div_u (.clock(clock), .en(en), .coord(col0_ff), .divisor(fs_use), .q_out(u_q));
   c2e_div u_div_v (.clock(clock), .en(en), .coord(row0_ff), .divisor(fs_use), .q_out(v_q));

   c2e_delay #(.WIDTH(c2e_pkg::FACE_W), .DEPTH(c2e_pkg::DIV_STEPS)) u_face_dly (
      .clock(clock), .en(en), .data_in(face0_ff), .data_out(face18)
   );

   // direction from the face basis
   logic signed [QW-1:0] dx_in, dy_in, dz_in, dx_ff, dy_ff, dz_ff;

   always_comb begin
      unique case (c2e_pkg::face_type'(face18))
         c2e_pkg::FACE_NEG_X: begin
            dx_in = -c2e_pkg::Q_ONE; dy_in = -v_q; dz_in = u_q;
         end
         c2e_pkg::FACE_POS_Y: begin
            dx_in = u_q; dy_in = c2e_pkg::Q_ONE; dz_in = v_q;
         end
         c2e_pkg::FACE_NEG_Y: begin
            dx_in = u_q; dy_in = -c2e_pkg::Q_ONE; dz_in = -v_q;
         end
         c2e_pkg::FACE_POS_Z: begin
            dx_in = u_q; dy_in = -v_q; dz_in = c2e_pkg::Q_ONE;
         end
         c2e_pkg::FACE_NEG_Z: begin
            dx_in = -u_q; dy_in = -v_q; dz_in = -c2e_pkg::Q_ONE;
         end
         default: begin
            dx_in = c2e_pkg::Q_ONE; dy_in = -v_q; dz_in = -u_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
   end

   // radial length in the x-z plane
   logic signed [c2e_pkg::SQ_W-1:0] xx_sq, zz_sq;
   logic [c2e_pkg::SQ_W-1:0]   xx_ff, zz_ff, sum_ff;
   logic [c2e_pkg::ROOT_W-1:0] root;

   assign xx_sq = dx_ff * dx_ff;
   assign zz_sq = dz_ff * dz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff  <= unsigned'(xx_sq);
         zz_ff  <= unsigned'(zz_sq);
         sum_ff <= xx_ff + zz_ff;
      end
   end

   c2e_sqrt u_sqrt (.clock(clock), .en(en), .radicand(sum_ff), .root(root));

   // longitude and polar angle
   logic signed [AW-1:0] lon_raw, lon_al, pol;
   logic signed [QW-1:0] y_al;

   c2e_cordic u_cordic_lon (
      .clock(clock), .en(en), .num(CIW'(dz_ff)), .den(CIW'(dx_ff)), .angle(lon_raw)
   );

   c2e_delay #(.WIDTH(AW), .DEPTH(20)) u_lon_dly (
      .clock(clock), .en(en), .data_in(lon_raw), .data_out(lon_al)
   );

   c2e_delay #(.WIDTH(QW), .DEPTH(20)) u_y_dly (
      .clock(clock), .en(en), .data_in(dy_ff), .data_out(y_al)
   );

   c2e_cordic u_cordic_pol (
      .clock(clock), .en(en), .num(signed'({1'b0, root})), .den(CIW'(y_al)), .angle(pol)
   );

   // fractions and scaling
   logic signed [AW:0] lon_sum;
   logic [FW-1:0]      lon_frac, pol_frac;
   logic [FW+c2e_pkg::SRC_COL_W-1:0] pcol_ff;
   logic [FW+c2e_pkg::SRC_ROW_W-1:0] prow_ff;

   always_comb begin
      lon_sum = (AW+1)'(lon_al) + (AW+1)'(c2e_pkg::HALF_TURN);
      if (lon_sum < 0) begin
         lon_frac = '0;
      end else if ((lon_sum >>> 4) > (AW+1)'(c2e_pkg::FRAC_ONE)) begin
         lon_frac = c2e_pkg::FRAC_ONE;
      end else begin
         lon_frac = FW'(lon_sum >>> 4);
      end
      if (pol < 0) begin
         pol_frac = '0;
      end else if ((pol >>> 3) > AW'(c2e_pkg::FRAC_ONE)) begin
         pol_frac = c2e_pkg::FRAC_ONE;
      end else begin
         pol_frac = FW'(pol >>> 3);
      end
   end

   logic [c2e_pkg::SRC_COL_W-1:0] sc_ff, col_out_ff;
   logic [c2e_pkg::SRC_ROW_W-1:0] sr_ff, row_out_ff;
   logic [c2e_pkg::SRC_IDX_W-1:0] iprod_ff, idx_out_ff;
   logic [c2e_pkg::SRC_ROW_W-1:0] sr_in;

   assign sr_in = prow_ff[FW+c2e_pkg::SRC_ROW_W-2:16];

   always_ff @(posedge clock) begin
      if (en) begin
         pcol_ff    <= lon_frac * sw_m1;
         prow_ff    <= pol_frac * sh_m1;
         sc_ff      <= pcol_ff[FW+c2e_pkg::SRC_COL_W-2:16];
         sr_ff      <= sr_in;
         iprod_ff   <= c2e_pkg::SRC_IDX_W'(sr_in) * c2e_pkg::SRC_IDX_W'(sw_use);
         col_out_ff <= sc_ff;
         row_out_ff <= sr_ff;
         idx_out_ff <= iprod_ff + c2e_pkg::SRC_IDX_W'(sc_ff);
      end
   end

   assign rsp_chan.valid     = vld_ff[DEPTH-1];
   assign rsp_chan.src_col   = col_out_ff;
   assign rsp_chan.src_row   = row_out_ff;
   assign rsp_chan.src_index = idx_out_ff;

endmodule

// File: sim/tb_cubemap_to_equirect_address.sv
`timescale 1ns / 1ps
// Testbench for cubemap_to_equirect_address: directed and random face pixels under
// several idle/stall phases and register settings, checked against an in-bench predictor.
// Depends on c2e_pkg, c2e_req_if, c2e_rsp_if and the block's RTL.
module tb_cubemap_to_equirect_address;

   typedef struct packed {
      logic [c2e_pkg::SRC_COL_W-1:0] src_col;
      logic [c2e_pkg::SRC_ROW_W-1:0] src_row;
      logic [c2e_pkg::SRC_IDX_W-1:0] src_index;
   } src_addr_type;

   localparam int LATENCY = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [c2e_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [c2e_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [c2e_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   c2e_req_if req_chan ();
   c2e_rsp_if rsp_chan ();

   cubemap_to_equirect_address dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.face = '0;
      req_chan.col = '0;
      req_chan.row = '0;
   end

   logic [c2e_pkg::FS_W-1:0] cfg_edge_len = 13'd1024;
   logic [c2e_pkg::SW_W-1:0] cfg_src_width = 14'd2048;
   logic [c2e_pkg::SH_W-1:0] cfg_src_height = 13'd1024;

   src_addr_type expected_addrs[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;

   function automatic longint shift_floor(longint val, int s);
      return val >>> s;
   endfunction

   function automatic longint face_coord(longint c, longint fs);
      longint q;
      q = (((2 * c + 1) << 16) / fs) - 65536;
      if (q > 131071) q = 131071;
      if (q < -131072) q = -131072;
      return q;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint vector_angle(longint num, longint den);
      longint ang, nd, nn;
      ang = 0;
      if (num == 0 && den == 0) return 0;
      if (den < 0) begin
         ang = (num >= 0) ? 524288 : -524288;
         den = -den;
         num = -num;
      end
      for (int i = 0; i < c2e_pkg::CORDIC_STEPS; i++) begin
         if (num >= 0) begin
            nd = den + shift_floor(num, i);
            nn = num - shift_floor(den, i);
            ang += longint'(c2e_pkg::ATAN_TURNS[i]);
         end else begin
            nd = den - shift_floor(num, i);
            nn = num + shift_floor(den, i);
            ang -= longint'(c2e_pkg::ATAN_TURNS[i]);
         end
         den = nd;
         num = nn;
      end
      return ang;
   endfunction

   function automatic longint turn_frac(longint units, int s);
      longint f;
      if (units < 0) return 0;
      f = units >>> s;
      return (f > 65536) ? 65536 : f;
   endfunction

   function automatic longint sat_q(longint t);
      if (t > 131071) return 131071;
      if (t < -131072) return -131072;
      return t;
   endfunction

   function automatic src_addr_type predict_src_addr(logic [2:0] face, logic [11:0] col,
                                                     logic [11:0] row);
      longint fs, sw, sh, u, v, x, y, z, r, lon, pol, lf, pf, sc, sr;
      src_addr_type a;
      fs = cfg_edge_len;
      if (fs < 1) fs = 1;
      if (fs > c2e_pkg::MAX_EDGE_LEN) fs = c2e_pkg::MAX_EDGE_LEN;
      sw = cfg_src_width;
      if (sw < 2) sw = 2;
      if (sw > c2e_pkg::MAX_SRC_WIDTH) sw = c2e_pkg::MAX_SRC_WIDTH;
      sh = cfg_src_height;
      if (sh < 2) sh = 2;
      if (sh > c2e_pkg::MAX_SRC_HEIGHT) sh = c2e_pkg::MAX_SRC_HEIGHT;
      u = face_coord(col, fs);
      v = face_coord(row, fs);
      case (face)
         c2e_pkg::FACE_NEG_X: begin x = -65536; y = -v;     z = u;      end
         c2e_pkg::FACE_POS_Y: begin x = u;      y = 65536;  z = v;      end
         c2e_pkg::FACE_NEG_Y: begin x = u;      y = -65536; z = -v;     end
         c2e_pkg::FACE_POS_Z: begin x = u;      y = -v;     z = 65536;  end
         c2e_pkg::FACE_NEG_Z: begin x = -u;     y = -v;     z = -65536; end
         default:             begin x = 65536;  y = -v;     z = -u;     end
      endcase
      x = sat_q(x);
      y = sat_q(y);
      z = sat_q(z);
      r = int_sqrt(longint'(x * x + z * z));
      lon = vector_angle(z, x);
      pol = vector_angle(r, y);
      lf = turn_frac(lon + 524288, 4);
      pf = turn_frac(pol, 3);
      sc = (lf * (sw - 1)) >> 16;
      sr = (pf * (sh - 1)) >> 16;
      a.src_col = sc[c2e_pkg::SRC_COL_W-1:0];
      a.src_row = sr[c2e_pkg::SRC_ROW_W-1:0];
      a.src_index = c2e_pkg::SRC_IDX_W'(sr * sw + sc);
      return a;
   endfunction

   task automatic send_pixel(logic [2:0] face, logic [11:0] col, logic [11:0] row);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.face <= face;
      req_chan.col <= col;
      req_chan.row <= row;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_addrs.push_back(predict_src_addr(face, col, row));
   endtask

   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      src_addr_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_addrs.size() == 0) begin
            $error("unexpected transfer: src_col %0d", rsp_chan.src_col);
            errors++;
         end else begin
            e = expected_addrs.pop_front();
            if (rsp_chan.src_col !== e.src_col) begin
               $error("src_col expected %0d actual %0d", e.src_col, rsp_chan.src_col);
               errors++;
            end
            if (rsp_chan.src_row !== e.src_row) begin
               $error("src_row expected %0d actual %0d", e.src_row, rsp_chan.src_row);
               errors++;
            end
            if (rsp_chan.src_index !== e.src_index) begin
               $error("src_index expected %0d actual %0d", e.src_index,
                      rsp_chan.src_index);
               errors++;
            end
         end
      end
   end

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic write_reg(c2e_pkg::reg_index_type idx, logic [31:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= c2e_pkg::CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         c2e_pkg::REG_EDGE_LEN:  cfg_edge_len = value[c2e_pkg::FS_W-1:0];
         c2e_pkg::REG_SRC_WIDTH: cfg_src_width = value[c2e_pkg::SW_W-1:0];
         default:                cfg_src_height = value[c2e_pkg::SH_W-1:0];
      endcase
   endtask

   task automatic configure(logic [31:0] fs, logic [31:0] sw, logic [31:0] sh);
      write_reg(c2e_pkg::REG_EDGE_LEN, fs);
      write_reg(c2e_pkg::REG_SRC_WIDTH, sw);
      write_reg(c2e_pkg::REG_SRC_HEIGHT, sh);
   endtask

   task automatic test_directed;
      logic [11:0] m;
      m = 12'(cfg_edge_len - 13'd1);
      for (int f = 0; f < 8; f++) send_pixel(f[2:0], 12'd0, 12'd0);
      for (int f = 0; f < 6; f++) send_pixel(f[2:0], m, m);
      send_pixel(c2e_pkg::FACE_POS_X, 12'd0, m);
      send_pixel(c2e_pkg::FACE_NEG_X, m, 12'd0);
      send_pixel(c2e_pkg::FACE_POS_Y, m >> 1, m >> 1);
      send_pixel(c2e_pkg::FACE_NEG_Y, m >> 1, m >> 1);
      send_pixel(c2e_pkg::FACE_POS_Z, 12'hFFF, 12'hFFF);
      send_pixel(c2e_pkg::FACE_NEG_Z, 12'hFFF, 12'd0);
      send_pixel(3'd7, 12'hAAA, 12'h555);
      send_pixel(c2e_pkg::FACE_NEG_X, m >> 1, m >> 1);
   endtask

   task automatic test_random(int count, int idle, int stall);
      int lim;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < count; i++) begin
         lim = (cfg_edge_len == 0) ? 0 : int'(cfg_edge_len) - 1;
         if (lim > 4095) lim = 4095;
         if ($urandom_range(9) == 0)
            send_pixel(3'($urandom), 12'($urandom), 12'($urandom));
         else
            send_pixel(3'($urandom_range(5)), 12'($urandom_range(lim)),
                       12'($urandom_range(lim)));
      end
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles <= 300;
      for (int i = 0; i < 120; i++)
         send_pixel(3'($urandom_range(5)), 12'($urandom_range(63)),
                    12'($urandom_range(63)));
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 0, 0);
      configure(64, 256, 128);
      test_directed();
      test_random(150, 47, 0);
      configure(1, 2, 2);
      test_directed();
      test_random(100, 0, 47);
      configure(4096, 8192, 4096);
      test_directed();
      test_random(150, 38, 38);
      configure(0, 16383, 8191);
      test_random(100, 20, 20);
      configure(13'h1FFF, 0, 1);
      test_random(100, 0, 0);
      configure(37, 1000, 333);
      test_backpressure();
      test_random(200, 38, 38);
      drain();
      configure(1024, 2048, 1024);
      test_random(100, 10, 10);
      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end
endmodule

// File: filelist.f
src/c2e_pkg.sv
src/c2e_req_if.sv
src/c2e_rsp_if.sv
src/c2e_delay.sv
src/c2e_div.sv
src/c2e_sqrt.sv
src/c2e_cordic.sv
src/cubemap_to_equirect_address.sv
sim/tb_cubemap_to_equirect_address.sv
